@@ rtl/ghs_pkg.sv @@
// ghs_pkg: shared types and constants for the glyph hint stripper.
// Used by the front end, command queue, back end, top level and testbench.
`default_nettype none
package ghs_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_EMPTY = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BBOX      = 2'd1;
  localparam logic [1:0] ERR_SHORT     = 2'd2;
  localparam logic [1:0] ERR_UNDERSIZE = 2'd3;

  localparam logic [31:0] MIN_GLYPH_SIZE = 32'd14;

  // command queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one queued command: expands into n_res results in the back end
  typedef struct packed {
    logic        is_err;
    logic [1:0]  err_code;
    logic        has_byte;
    logic [7:0]  byte_val;
    logic [1:0]  pad;
    logic [31:0] offset;
    logic [2:0]  n_res;
  } ghs_cmd_t;

endpackage
`default_nettype wire

@@ rtl/ghs_in_if.sv @@
// ghs_in_if: input channel of the glyph hint stripper (valid/ready + request).
// Stands alone; widths follow the request fields.
`default_nettype none
interface ghs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       glyph_end;

  modport source (output valid, output req_type, output data_byte, output glyph_end,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input glyph_end,
                output ready);
endinterface
`default_nettype wire

@@ rtl/ghs_out_if.sv @@
// ghs_out_if: result channel of the glyph hint stripper (valid/ready + result).
// Stands alone; widths follow the result fields.
`default_nettype none
interface ghs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [31:0] glyph_offset;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, output out_kind, output out_byte, output glyph_offset,
                  output error_code, output last, input ready);
  modport sink (input valid, input out_kind, input out_byte, input glyph_offset,
                input error_code, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/glyph_hint_stripper.sv @@
// glyph_hint_stripper: top level; strips hinting instructions from glyph data.
// Depends on ghs_pkg, ghs_in_if, ghs_out_if, ghs_front, ghs_cmd_fifo, ghs_back.
//
//   channel | dir | payload                                          | handshake
//   in_s    | in  | req_type, data_byte, glyph_end                   | valid/ready
//   out_m   | out | out_kind, out_byte, glyph_offset, error_code, last | valid/ready
//
// The front end takes one item per cycle; each item with results queues one command.
// The back end sends one result per cycle unless out_m stalls; a glyph end gives
// up to five results (byte, up to three pad bytes, offset), so in_s.ready drops while the
// four-entry command queue is full.
// Reset is synchronous and clears control state only; no clearing pass.
`default_nettype none
module glyph_hint_stripper import ghs_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ghs_in_if.sink    in_s,
  ghs_out_if.source out_m
);

  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  ghs_cmd_t cmd;
  ghs_cmd_t head;

  ghs_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (in_s),
    .q_full (q_full),
    .push   (push),
    .cmd    (cmd)
  );

  ghs_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (head)
  );

  ghs_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (q_empty),
    .head  (head),
    .pop   (pop),
    .out_m (out_m)
  );

endmodule
`default_nettype wire

@@ rtl/ghs_front.sv @@
// ghs_front: parses the glyph byte stream, tracks glyph state and offsets,
// and issues one command per item that has results. Depends on ghs_pkg, ghs_in_if.
`default_nettype none
module ghs_front import ghs_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ghs_in_if.sink     in_s,
  input  wire logic  q_full,
  output logic       push,
  output ghs_cmd_t   cmd
);

  typedef enum logic [6:0] {
    PH_HDR    = 7'b0000001,
    PH_ENDPTS = 7'b0000010,
    PH_LENHI  = 7'b0000100,
    PH_LENLO  = 7'b0001000,
    PH_INSTR  = 7'b0010000,
    PH_REST   = 7'b0100000,
    PH_COMP   = 7'b1000000
  } phase_t;

  // header byte positions that complete a 16-bit field
  localparam logic [3:0] IDX_CONTOURS = 4'd1;
  localparam logic [3:0] IDX_XMIN     = 4'd3;
  localparam logic [3:0] IDX_YMIN     = 4'd5;
  localparam logic [3:0] IDX_XMAX     = 4'd7;
  localparam logic [31:0] ENDPTS_BASE = 32'd9;

  phase_t                 phase_r, phase_nxt;
  logic [31:0]            idx_r, idx_nxt;
  logic [31:0]            kept_r, kept_nxt;
  logic [OFFSET_BITS-1:0] running_r, running_nxt;
  logic [OFFSET_BITS-1:0] gstart_r, gstart_nxt;
  logic [1:0]             err_r, err_nxt;
  logic [15:0]            cc_r, cc_nxt;
  logic [15:0]            xmin_r, xmin_nxt;
  logic [15:0]            ymin_r, ymin_nxt;
  logic [7:0]             hi_r, hi_nxt;
  logic [15:0]            left_r, left_nxt;

  logic accept;
  logic want_push;

  assign in_s.ready = !q_full;
  assign accept     = in_s.valid && in_s.ready;
  // queue a command only on an accepted transfer
  assign push       = want_push && accept;

  always_comb begin
    logic [15:0] v;
    logic        pass;
    logic [7:0]  ob;
    logic        bbox_bad;
    logic [31:0] kept_inc;
    logic [31:0] endpts_last;
    logic [1:0]  pad;
    logic [31:0] grown;

    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    kept_nxt    = kept_r;
    running_nxt = running_r;
    gstart_nxt  = gstart_r;
    err_nxt     = err_r;
    cc_nxt      = cc_r;
    xmin_nxt    = xmin_r;
    ymin_nxt    = ymin_r;
    hi_nxt      = hi_r;
    left_nxt    = left_r;
    want_push   = 1'b0;
    cmd         = '0;

    v           = {hi_r, in_s.data_byte};
    pass        = 1'b1;
    ob          = in_s.data_byte;
    bbox_bad    = 1'b0;
    kept_inc    = '0;
    endpts_last = {15'd0, cc_r, 1'b0} + ENDPTS_BASE;
    pad         = '0;
    grown       = '0;

    if (err_r != ERR_NONE) begin
      want_push    = 1'b1;
      cmd.is_err   = 1'b1;
      cmd.err_code = err_r;
      cmd.n_res    = 3'd1;
    end else begin
      case (in_s.req_type)
        REQ_EMPTY, REQ_END: begin
          want_push = 1'b1;
          if (phase_r != PH_HDR || idx_r != 32'd0) begin
            err_nxt      = ERR_SHORT;
            cmd.is_err   = 1'b1;
            cmd.err_code = ERR_SHORT;
            cmd.n_res    = 3'd1;
          end else begin
            cmd.offset = 32'(running_r);
            cmd.n_res  = 3'd1;
            if (in_s.req_type == REQ_END) begin
              running_nxt = '0;
            end
          end
        end
        REQ_DATA: begin
          case (phase_r)
            PH_HDR: begin
              if (idx_r == 32'd0) begin
                gstart_nxt = running_r;
              end
              if (!idx_r[0]) begin
                hi_nxt = in_s.data_byte;
              end else begin
                // idx stays below ten in the header
                case (idx_r[3:0])
                  IDX_CONTOURS: cc_nxt = v;
                  IDX_XMIN:     xmin_nxt = v;
                  IDX_YMIN:     ymin_nxt = v;
                  IDX_XMAX:     bbox_bad = $signed(xmin_r) > $signed(v);
                  default: begin
                    bbox_bad = $signed(ymin_r) > $signed(v);
                    if (cc_r[15]) begin
                      phase_nxt = PH_COMP;
                    end else if (cc_r == 16'd0) begin
                      phase_nxt = PH_LENHI;
                    end else begin
                      phase_nxt = PH_ENDPTS;
                    end
                  end
                endcase
              end
            end
            PH_ENDPTS: begin
              if (idx_r == endpts_last) begin
                phase_nxt = PH_LENHI;
              end
            end
            PH_LENHI: begin
              hi_nxt    = in_s.data_byte;
              ob        = 8'd0;
              phase_nxt = PH_LENLO;
            end
            PH_LENLO: begin
              left_nxt  = v;
              ob        = 8'd0;
              phase_nxt = (v != 16'd0) ? PH_INSTR : PH_REST;
            end
            PH_INSTR: begin
              pass     = 1'b0;
              left_nxt = left_r - 16'd1;
              if (left_nxt == 16'd0) begin
                phase_nxt = PH_REST;
              end
            end
            default: ;
          endcase

          kept_inc = kept_r + 32'(pass);

          if (bbox_bad) begin
            want_push    = 1'b1;
            err_nxt      = ERR_BBOX;
            cmd.is_err   = 1'b1;
            cmd.err_code = ERR_BBOX;
            cmd.n_res    = 3'd1;
          end else if (!in_s.glyph_end) begin
            idx_nxt  = idx_r + 32'd1;
            kept_nxt = kept_inc;
            if (pass) begin
              want_push    = 1'b1;
              cmd.has_byte = 1'b1;
              cmd.byte_val = ob;
              cmd.n_res    = 3'd1;
            end
          end else if (phase_nxt != PH_REST && phase_nxt != PH_COMP) begin
            want_push    = 1'b1;
            err_nxt      = ERR_SHORT;
            cmd.is_err   = 1'b1;
            cmd.err_code = ERR_SHORT;
            cmd.n_res    = 3'd1;
          end else if (kept_inc < MIN_GLYPH_SIZE) begin
            want_push    = 1'b1;
            err_nxt      = ERR_UNDERSIZE;
            cmd.is_err   = 1'b1;
            cmd.err_code = ERR_UNDERSIZE;
            cmd.n_res    = 3'd1;
          end else begin
            // kept bytes = byte count minus dropped instructions
            pad          = 2'(32'd0 - kept_inc);
            grown        = kept_inc + 32'(pad);
            want_push    = 1'b1;
            cmd.has_byte = pass;
            cmd.byte_val = ob;
            cmd.pad      = pad;
            cmd.offset   = 32'(gstart_r);
            cmd.n_res    = 3'(pass) + 3'(pad) + 3'd1;
            running_nxt  = running_r + grown[OFFSET_BITS-1:0];
            phase_nxt    = PH_HDR;
            idx_nxt      = '0;
            kept_nxt     = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR;
      idx_r     <= '0;
      kept_r    <= '0;
      running_r <= '0;
      err_r     <= ERR_NONE;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      kept_r    <= kept_nxt;
      running_r <= running_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gstart_r <= gstart_nxt;
      cc_r     <= cc_nxt;
      xmin_r   <= xmin_nxt;
      ymin_r   <= ymin_nxt;
      hi_r     <= hi_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ghs_cmd_fifo.sv @@
// ghs_cmd_fifo: short command queue between the front and back ends.
// Depends on ghs_pkg for the command type and depth.
`default_nettype none
module ghs_cmd_fifo import ghs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire ghs_cmd_t cmd_in,
  input  wire logic     pop,
  output logic          full,
  output logic          empty,
  output ghs_cmd_t      head
);

  ghs_cmd_t           entries_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    count_r;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ghs_back.sv @@
// ghs_back: expands queued commands into result transfers, one per cycle
// unless stalled, via a registered output stage. Depends on ghs_pkg, ghs_out_if.
`default_nettype none
module ghs_back import ghs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     empty,
  input  wire ghs_cmd_t head,
  output logic          pop,
  ghs_out_if.source     out_m
);

  logic [2:0]  step_r;
  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [31:0] off_r;
  logic [1:0]  code_r;
  logic        last_r;

  logic        load;
  logic        is_last;
  logic [1:0]  kind_nxt;
  logic [7:0]  byte_nxt;
  logic [31:0] off_nxt;
  logic [1:0]  code_nxt;

  assign load    = !empty && (!valid_r || out_m.ready);
  assign is_last = (step_r == head.n_res - 3'd1);
  assign pop     = load && is_last;

  always_comb begin
    kind_nxt = KIND_DATA;
    byte_nxt = 8'd0;
    off_nxt  = '0;
    code_nxt = ERR_NONE;
    if (head.is_err) begin
      kind_nxt = KIND_ERROR;
      code_nxt = head.err_code;
    end else if (head.has_byte && step_r == 3'd0) begin
      byte_nxt = head.byte_val;
    end else if (step_r < 3'(head.has_byte) + 3'(head.pad)) begin
      byte_nxt = 8'd0;
    end else begin
      kind_nxt = KIND_OFFSET;
      off_nxt  = head.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        step_r  <= is_last ? 3'd0 : step_r + 3'd1;
      end else if (out_m.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      off_r  <= off_nxt;
      code_r <= code_nxt;
      last_r <= is_last;
    end
  end

  assign out_m.valid        = valid_r;
  assign out_m.out_kind     = kind_r;
  assign out_m.out_byte     = byte_r;
  assign out_m.glyph_offset = off_r;
  assign out_m.error_code   = code_r;
  assign out_m.last         = last_r;

endmodule
`default_nettype wire

@@ tb/ghs_tb_pkg.sv @@
// ghs_tb_pkg: scoreboard for the glyph hint stripper testbench.
// Tracks glyph parsing, predicts the stripped byte stream and offset records.
// Depends on ghs_pkg for request, result and error codes.
`timescale 1ns / 1ps
package ghs_tb_pkg;
  import ghs_pkg::*;

  // request code with no meaning; the block drops it
  localparam logic [1:0] REQ_NOISE = 2'd3;

  typedef enum logic [2:0] {
    GP_HDR,
    GP_ENDPTS,
    GP_LENHI,
    GP_LENLO,
    GP_INSTR,
    GP_REST,
    GP_COMP
  } glyph_phase_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] offset;
    logic [1:0]  code;
    logic        last;
  } strip_res_t;

  typedef logic [7:0] glyph_bytes_t [$];

  class glyph_strip_scoreboard;
    glyph_phase_t parse_phase;
    logic [31:0]  byte_idx;
    logic [15:0]  contours;
    logic [15:0]  corner_min [2];
    logic [7:0]   hi_byte;
    logic [15:0]  instr_left;
    logic [15:0]  instr_total;
    logic [31:0]  glyph_start;
    logic [31:0]  run_offset;
    logic [1:0]   err_latch;
    strip_res_t   stripped_q [$];
    int           mismatches;

    function new();
      parse_phase   = GP_HDR;
      byte_idx      = '0;
      contours      = '0;
      corner_min[0] = '0;
      corner_min[1] = '0;
      hi_byte       = '0;
      instr_left    = '0;
      instr_total   = '0;
      glyph_start   = '0;
      run_offset    = '0;
      err_latch     = ERR_NONE;
      mismatches    = 0;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] data, logic [31:0] offset,
                       logic [1:0] code, logic last);
      strip_res_t r;
      r.kind   = kind;
      r.data   = data;
      r.offset = offset;
      r.code   = code;
      r.last   = last;
      stripped_q = {stripped_q, r};
    endfunction

    function void raise_error(logic [1:0] code);
      err_latch = code;
      push(KIND_ERROR, 8'd0, 32'd0, code, 1'b1);
    endfunction

    // predict the results of one accepted transfer
    function void note_request(logic [1:0] rt, logic [7:0] b, logic ge);
      logic [15:0] v;
      logic        pass;
      logic [7:0]  ob;
      logic [31:0] stripped_size;
      logic [1:0]  pad;
      v    = {hi_byte, b};
      pass = 1'b1;
      ob   = b;
      if (err_latch != ERR_NONE) begin
        push(KIND_ERROR, 8'd0, 32'd0, err_latch, 1'b1);
        return;
      end
      if (rt == REQ_NOISE)
        return;
      if (rt == REQ_EMPTY || rt == REQ_END) begin
        if (parse_phase != GP_HDR || byte_idx != 0) begin
          raise_error(ERR_SHORT);
          return;
        end
        push(KIND_OFFSET, 8'd0, run_offset, ERR_NONE, 1'b1);
        if (rt == REQ_END)
          run_offset = '0;
        return;
      end

      case (parse_phase)
        GP_HDR: begin
          if (byte_idx == 0)
            glyph_start = run_offset;
          if (!byte_idx[0]) begin
            hi_byte = b;
          end else if (byte_idx == 1) begin
            contours = v;
          end else if (byte_idx == 3) begin
            corner_min[0] = v;
          end else if (byte_idx == 5) begin
            corner_min[1] = v;
          end else if (byte_idx == 7) begin
            if ($signed(corner_min[0]) > $signed(v)) begin
              raise_error(ERR_BBOX);
              return;
            end
          end else begin
            if ($signed(corner_min[1]) > $signed(v)) begin
              raise_error(ERR_BBOX);
              return;
            end
            if (contours[15])
              parse_phase = GP_COMP;
            else if (contours == 0)
              parse_phase = GP_LENHI;
            else
              parse_phase = GP_ENDPTS;
          end
        end
        GP_ENDPTS: begin
          if (byte_idx == 32'd9 + {15'd0, contours, 1'b0})
            parse_phase = GP_LENHI;
        end
        GP_LENHI: begin
          hi_byte     = b;
          ob          = 8'd0;
          parse_phase = GP_LENLO;
        end
        GP_LENLO: begin
          instr_total = v;
          instr_left  = v;
          ob          = 8'd0;
          parse_phase = (v != 0) ? GP_INSTR : GP_REST;
        end
        GP_INSTR: begin
          pass       = 1'b0;
          instr_left = instr_left - 16'd1;
          if (instr_left == 0)
            parse_phase = GP_REST;
        end
        default: ;
      endcase
      byte_idx = byte_idx + 32'd1;

      if (!ge) begin
        if (pass)
          push(KIND_DATA, ob, 32'd0, ERR_NONE, 1'b1);
        return;
      end
      if (parse_phase != GP_REST && parse_phase != GP_COMP) begin
        raise_error(ERR_SHORT);
        return;
      end
      stripped_size = byte_idx -
                      ((parse_phase == GP_REST) ? {16'd0, instr_total} : 32'd0);
      if (stripped_size < MIN_GLYPH_SIZE) begin
        raise_error(ERR_UNDERSIZE);
        return;
      end
      if (pass)
        push(KIND_DATA, ob, 32'd0, ERR_NONE, 1'b0);
      pad = 2'd0 - stripped_size[1:0];
      for (int i = 0; i < pad; i++)
        push(KIND_DATA, 8'd0, 32'd0, ERR_NONE, 1'b0);
      push(KIND_OFFSET, 8'd0, glyph_start, ERR_NONE, 1'b1);
      run_offset  = run_offset + stripped_size + {30'd0, pad};
      parse_phase = GP_HDR;
      byte_idx    = '0;
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic [31:0] offset,
                               logic [1:0] code, logic last);
      strip_res_t e;
      if (stripped_q.size() == 0) begin
        $error("unexpected result: out_kind %0d out_byte %0h glyph_offset %0h", kind, data,
               offset);
        mismatches++;
        return;
      end
      e = stripped_q.pop_front();
      if (kind !== e.kind) begin
        $error("out_kind: expected %0d, actual %0d", e.kind, kind);
        mismatches++;
      end
      if (data !== e.data) begin
        $error("out_byte: expected %0h, actual %0h", e.data, data);
        mismatches++;
      end
      if (offset !== e.offset) begin
        $error("glyph_offset: expected %0h, actual %0h", e.offset, offset);
        mismatches++;
      end
      if (code !== e.code) begin
        $error("error_code: expected %0d, actual %0d", e.code, code);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
// tb_top: drives glyph table streams into glyph_hint_stripper and checks results.
// Depends on ghs_pkg, ghs_in_if, ghs_out_if and the scoreboard in ghs_tb_pkg.
`timescale 1ns / 1ps
module tb_top;
  import ghs_pkg::*;
  import ghs_tb_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int GAP_PCT   [4] = '{0, 54, 0, 24};
  localparam int STALL_PCT [4] = '{0, 0, 54, 24};

  logic clk;
  logic rst_n;
  int   send_gap_pct;
  int   recv_stall_pct;
  int   data_items;
  int   quiet_cycles;

  glyph_strip_scoreboard sb;

  ghs_in_if  in_ch ();
  ghs_out_if out_ch ();

  glyph_hint_stripper dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // check results; end the run if nothing moves for too long
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_kind, out_ch.out_byte, out_ch.glyph_offset,
                      out_ch.error_code, out_ch.last);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] rt, input logic [7:0] b, input logic ge);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rt;
    in_ch.data_byte <= b;
    in_ch.glyph_end <= ge;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(rt, b, ge);
    if (rt != REQ_NOISE)
      data_items++;
  endtask

  task automatic send_glyph(input glyph_bytes_t bytes);
    foreach (bytes[i])
      send_item(REQ_DATA, bytes[i], i == bytes.size() - 1);
  endtask

  // hold the sender until every predicted result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.stripped_q.size() != 0)
      @(posedge clk);
  endtask

  // bad_axis: 0 well-formed box, 1 xmin above xmax, 2 ymin above ymax
  function automatic glyph_bytes_t build_glyph(bit composite, int nc, int ninstr, int nrest,
                                               int bad_axis);
    glyph_bytes_t q;
    logic [15:0]  hdr [5];
    int           lo;
    int           hi;
    hdr[0] = composite ? (16'h8000 | 16'($urandom_range(0, 32767))) : 16'(nc);
    for (int a = 0; a < 2; a++) begin
      if (bad_axis == a + 1) begin
        lo = $urandom_range(0, 65534) - 32767;
        hi = lo - 1 - $urandom_range(0, lo + 32767);
      end else begin
        lo = $urandom_range(0, 65535) - 32768;
        hi = lo + $urandom_range(0, 32767 - lo);
      end
      hdr[1 + a] = 16'(lo);
      hdr[3 + a] = 16'(hi);
    end
    for (int k = 0; k < 5; k++) begin
      q = {q, hdr[k][15:8]};
      q = {q, hdr[k][7:0]};
    end
    if (!composite) begin
      repeat (2 * nc) q = {q, 8'($urandom)};
      q = {q, 8'(ninstr >> 8)};
      q = {q, 8'(ninstr)};
      repeat (ninstr) q = {q, 8'($urandom)};
    end
    repeat (nrest) q = {q, 8'($urandom)};
    return q;
  endfunction

  initial begin
    glyph_bytes_t g;
    int           sel;
    int           nc;
    int           ninstr;
    int           nrest;
    int           cut;
    int           base;
    bit           comp;

    sb              = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_DATA;
    in_ch.data_byte = 8'd0;
    in_ch.glyph_end = 1'b0;
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    data_items      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: markers, unknown request, one simple glyph at the field extremes
    send_item(REQ_EMPTY, 8'h00, 1'b0);
    send_item(REQ_NOISE, 8'hFF, 1'b1);
    g = build_glyph(1'b0, 1, 2, 1, 0);
    g[2]  = 8'h80; g[3]  = 8'h00;   // xmin at the most negative value
    g[6]  = 8'h7F; g[7]  = 8'hFF;   // xmax at the most positive value
    g[4]  = 8'h12; g[5]  = 8'h34;   // ymin equal to ymax
    g[8]  = 8'h12; g[9]  = 8'h34;
    g[10] = 8'hFF; g[11] = 8'h00;
    g[14] = 8'hFF; g[15] = 8'h00;
    g[16] = 8'hFF;
    send_glyph(g);
    send_item(REQ_END, 8'hFF, 1'b1);
    base = data_items;

    for (int p = 0; p < 4; p++) begin
      send_gap_pct   = GAP_PCT[p];
      recv_stall_pct = STALL_PCT[p];
      while (data_items < base + (p + 1) * ITEMS_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          send_item(REQ_NOISE, 8'($urandom), 1'($urandom));
        end else if (sel < 8) begin
          send_item(REQ_END, 8'($urandom), 1'($urandom));
        end else if (sel < 16) begin
          send_item(REQ_EMPTY, 8'($urandom), 1'($urandom));
        end else begin
          comp = ($urandom_range(0, 99) < 20);
          sel  = $urandom_range(0, 99);
          nc   = (sel < 60) ? $urandom_range(0, 2) :
                 (sel < 90) ? $urandom_range(3, 6) : $urandom_range(7, 16);
          sel  = $urandom_range(0, 99);
          ninstr = (sel < 20) ? 0 :
                   (sel < 85) ? $urandom_range(1, 8) :
                   (sel < 97) ? $urandom_range(9, 40) : $urandom_range(256, 264);
          nrest = comp ? $urandom_range(4, 12) : $urandom_range(0, 9);
          // a simple glyph with no contours needs two more bytes to reach the minimum
          if (!comp && nc == 0 && nrest < 2)
            nrest = 2;
          send_glyph(build_glyph(comp, nc, ninstr, nrest, 0));
        end
      end
      wait_drained();
    end

    // the error latches until reset, so provoke exactly one kind at the very end
    case ($urandom_range(0, 4))
      0: send_glyph(build_glyph(1'b0, 1, 1, 3, 1));
      1: send_glyph(build_glyph(1'b1, 0, 0, 4, 2));
      2: begin
        // glyph ends before its instructions are complete
        nc     = $urandom_range(0, 3);
        ninstr = $urandom_range(0, 4);
        g      = build_glyph(1'b0, nc, ninstr, 3, 0);
        cut    = $urandom_range(1, 11 + 2 * nc + ninstr);
        while (g.size() > cut)
          void'(g.pop_back());
        send_glyph(g);
      end
      3: begin
        // marker arrives while a glyph header is partly received
        g   = build_glyph(1'b0, 0, 0, 4, 0);
        cut = $urandom_range(1, 9);
        for (int i = 0; i < cut; i++)
          send_item(REQ_DATA, g[i], 1'b0);
        send_item($urandom_range(0, 1) ? REQ_EMPTY : REQ_END, 8'($urandom), 1'($urandom));
      end
      default: send_glyph(build_glyph(1'b0, 0, $urandom_range(0, 3), $urandom_range(0, 1), 0));
    endcase
    send_item(REQ_DATA, 8'($urandom), 1'b1);
    send_item(REQ_NOISE, 8'($urandom), 1'($urandom));
    send_item(REQ_EMPTY, 8'($urandom), 1'($urandom));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.stripped_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
